// File: rtl/core/hex_to_square_grid_resample_index_defines.svh
// assertion macros shared by the resample index rtl
// expects clk and arst_n in the scope where a macro is used
`ifndef HEX_TO_SQUARE_GRID_RESAMPLE_INDEX_DEFINES_SVH
`define HEX_TO_SQUARE_GRID_RESAMPLE_INDEX_DEFINES_SVH

// same-cycle implication
`define HSG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HSG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/hsg_pkg.sv
// shared types and constants of the hex to square grid resample index block
// no dependencies
package hsg_pkg;

	localparam int NUM_W  = 28;  // position width, also quotient width
	localparam int STEP_W = 16;  // step and resolution width
	localparam int CNT_W  = 13;  // row and column count width
	localparam int IDX_W  = 24;  // linear index width

	typedef enum logic [2:0] {
		REG_HEX_X_STEP    = 3'd0,
		REG_HEX_Y_STEP    = 3'd1,
		REG_SQR_X_RES     = 3'd2,
		REG_SQR_Y_RES     = 3'd3,
		REG_HEX_COLS_ODD  = 3'd4,
		REG_HEX_COLS_EVEN = 3'd5,
		REG_HEX_ROWS      = 3'd6
	} reg_idx_t;

	// configuration after zero-step and count saturation fixups
	typedef struct packed {
		logic [STEP_W-1:0] xs;
		logic [STEP_W-1:0] ys;
		logic [CNT_W-1:0]  nodd;
		logic [CNT_W-1:0]  neven;
		logic [CNT_W-1:0]  nrows;
	} cfg_t;

endpackage

// File: rtl/core/hsg_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on hsg_pkg
module hsg_div (
	input  logic                      clk,
	input  logic                      en,
	input  logic [hsg_pkg::NUM_W-1:0] num,
	input  logic [hsg_pkg::STEP_W-1:0] den,
	output logic [hsg_pkg::NUM_W-1:0] quo,
	output logic [hsg_pkg::STEP_W-1:0] rem
);
	import hsg_pkg::*;

	logic [STEP_W-1:0] rem_s [0:NUM_W];
	logic [NUM_W-1:0]  num_s [0:NUM_W];
	logic [NUM_W-1:0]  quo_s [0:NUM_W];

	assign rem_s[0] = '0;
	assign num_s[0] = num;
	assign quo_s[0] = '0;

	for (genvar g = 0; g < NUM_W; g++) begin : g_stage
		logic [STEP_W:0] shifted;
		logic            fits;
		assign shifted = {rem_s[g], num_s[g][NUM_W-1]};
		assign fits    = shifted >= {1'b0, den};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= fits ? STEP_W'(shifted - {1'b0, den}) : shifted[STEP_W-1:0];
				num_s[g+1] <= {num_s[g][NUM_W-2:0], 1'b0};
				quo_s[g+1] <= {quo_s[g][NUM_W-2:0], fits};
			end
		end
	end

	assign quo = quo_s[NUM_W];
	assign rem = rem_s[NUM_W];

endmodule

// File: rtl/core/hsg_pick.sv
// candidate distances, index arithmetic, nearest pick and end clamp (four stages)
// depends on hsg_pkg
module hsg_pick (
	input  logic                       clk,
	input  logic                       en,
	input  hsg_pkg::cfg_t              cfg,
	input  logic [24:0]                total,
	input  logic [hsg_pkg::NUM_W-1:0]  ucol,
	input  logic [hsg_pkg::STEP_W-1:0] rx,
	input  logic [hsg_pkg::NUM_W-1:0]  row1,
	input  logic [hsg_pkg::STEP_W-1:0] ry,
	output logic [hsg_pkg::IDX_W-1:0]  index,
	output logic                       oor
);
	import hsg_pkg::*;

	// stage a: distances in doubled units, shifted column, row base
	logic [STEP_W:0]   rx2;
	logic              right_half;
	logic [17:0]       dsx;
	logic [NUM_W-1:0]  scol;
	logic              even_row;
	logic [CNT_W:0]    sum;

	assign rx2        = {rx, 1'b0};
	assign right_half = rx2 >= {1'b0, cfg.xs};
	assign even_row   = !row1[0];
	assign sum        = {1'b0, cfg.nodd} + {1'b0, cfg.neven};

	always_comb begin
		if (right_half) begin
			dsx  = 18'(rx2 - {1'b0, cfg.xs});
			scol = ucol;
		end else if (ucol != '0) begin
			dsx  = 18'(rx2) + 18'(cfg.xs);
			scol = ucol - NUM_W'(1);
		end else begin
			// left of the first shifted sample
			dsx  = 18'({1'b0, cfg.xs} - rx2);
			scol = '0;
		end
	end

	logic [17:0]      dx1_s1, dx2_s1;
	logic [STEP_W:0]  dy1_s1, dy2_s1;
	logic [NUM_W-1:0] ucol_s1, scol_s1;
	logic [40:0]      base_s1;
	logic             even_s1, last_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dx1_s1  <= even_row ? 18'(rx2) : dsx;
			dx2_s1  <= even_row ? dsx : 18'(rx2);
			dy1_s1  <= {ry, 1'b0};
			dy2_s1  <= {STEP_W'(cfg.ys - ry), 1'b0};
			ucol_s1 <= ucol;
			scol_s1 <= scol;
			base_s1 <= 41'(row1[NUM_W-1:1]) * 41'(sum);
			even_s1 <= even_row;
			last_s1 <= (29'(row1) + 29'd1) == 29'(cfg.nrows);
		end
	end

	// stage b: squares and candidate indexes
	logic [41:0] p_full, ps_full, pn_full;
	logic [41:0] p1_full, p2_full;
	assign p_full  = 42'(base_s1) + 42'(ucol_s1);
	assign ps_full = 42'(base_s1) + 42'(cfg.nodd) + 42'(scol_s1);
	assign pn_full = 42'(base_s1) + 42'(sum) + 42'(ucol_s1);
	assign p1_full = even_s1 ? p_full : ps_full;
	assign p2_full = even_s1 ? ps_full : pn_full;

	logic [35:0] sx1_s2, sx2_s2;
	logic [33:0] sy1_s2, sy2_s2;
	logic [24:0] p1_s2, p2_s2;
	logic        last_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sx1_s2  <= 36'(dx1_s1) * 36'(dx1_s1);
			sx2_s2  <= 36'(dx2_s1) * 36'(dx2_s1);
			sy1_s2  <= 34'(dy1_s1) * 34'(dy1_s1);
			sy2_s2  <= 34'(dy2_s1) * 34'(dy2_s1);
			// saturate: anything this large is past the grid end anyway
			p1_s2   <= (|p1_full[41:25]) ? '1 : p1_full[24:0];
			p2_s2   <= (|p2_full[41:25]) ? '1 : p2_full[24:0];
			last_s2 <= last_s1;
		end
	end

	// stage c: squared distances
	logic [36:0] d1_s3, d2_s3;
	logic [24:0] p1_s3, p2_s3;
	logic        last_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s3   <= 37'(sx1_s2) + 37'(sy1_s2);
			d2_s3   <= 37'(sx2_s2) + 37'(sy2_s2);
			p1_s3   <= p1_s2;
			p2_s3   <= p2_s2;
			last_s3 <= last_s2;
		end
	end

	// stage d: pick the nearer, lower row on ties and on the last row, then clamp
	logic [24:0] pt;
	assign pt = (d1_s3 <= d2_s3 || last_s3) ? p1_s3 : p2_s3;

	logic [24:0] total_m1;
	assign total_m1 = total - 25'd1;

	logic [IDX_W-1:0] index_s4;
	logic             oor_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			if (total == '0) begin
				index_s4 <= '0;
				oor_s4   <= 1'b1;
			end else if (pt >= total) begin
				index_s4 <= total_m1[IDX_W-1:0];
				oor_s4   <= 1'b1;
			end else begin
				index_s4 <= pt[IDX_W-1:0];
				oor_s4   <= 1'b0;
			end
		end
	end

	assign index = index_s4;
	assign oor   = oor_s4;

endmodule

// File: rtl/core/hex_to_square_grid_resample_index.sv
// Maps a square grid pixel (out_col, out_row) to the linear index of the nearest sample of a
// hexagonal source grid, along with the pixel position in fixed point. One pixel is taken in
// every cycle while the output is not stalled; the pipeline is made up of the two 28-step
// restoring dividers (x over the column step, y over the row step) that run side by side, plus
// two input stages and four stages of distance, index and clamp arithmetic. A stall on the
// output holds the whole pipeline. Configuration writes always complete at once.
// depends on hsg_pkg, hsg_div, hsg_pick and the defines header
`include "hex_to_square_grid_resample_index_defines.svh"

module hex_to_square_grid_resample_index #(
	parameter int MAX_DIM   = 4096,
	parameter int FRAC_BITS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [2:0]                 cfg_index,
	input  logic [15:0]                cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [11:0]                out_col,
	input  logic [11:0]                out_row,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [hsg_pkg::IDX_W-1:0]  source_index,
	output logic [hsg_pkg::NUM_W-1:0]  x_pos,
	output logic [hsg_pkg::NUM_W-1:0]  y_pos,
	output logic                       out_of_range
);
	import hsg_pkg::*;

	localparam logic [STEP_W-1:0] ONE_FX = STEP_W'(1 << FRAC_BITS);
	localparam logic [16:0]       MAXD   = 17'(MAX_DIM);
	localparam int                LAT    = NUM_W + 6;

	// configuration registers
	logic [STEP_W-1:0] hex_x_step_q, hex_y_step_q, sqr_x_res_q, sqr_y_res_q;
	logic [CNT_W-1:0]  cols_odd_q, cols_even_q, rows_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hex_x_step_q <= ONE_FX;
			hex_y_step_q <= ONE_FX;
			sqr_x_res_q  <= ONE_FX;
			sqr_y_res_q  <= ONE_FX;
			cols_odd_q   <= '0;
			cols_even_q  <= '0;
			rows_q       <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_HEX_X_STEP:    hex_x_step_q <= cfg_data;
				REG_HEX_Y_STEP:    hex_y_step_q <= cfg_data;
				REG_SQR_X_RES:     sqr_x_res_q  <= cfg_data;
				REG_SQR_Y_RES:     sqr_y_res_q  <= cfg_data;
				REG_HEX_COLS_ODD:  cols_odd_q   <= cfg_data[CNT_W-1:0];
				REG_HEX_COLS_EVEN: cols_even_q  <= cfg_data[CNT_W-1:0];
				REG_HEX_ROWS:      rows_q       <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	function automatic logic [CNT_W-1:0] sat_dim(input logic [CNT_W-1:0] v);
		logic [16:0] maxd;
		maxd = MAXD;
		return ({4'b0, v} > maxd) ? maxd[CNT_W-1:0] : v;
	endfunction

	cfg_t cfg_c;
	always_comb begin
		cfg_c.xs    = (hex_x_step_q == '0) ? STEP_W'(1) : hex_x_step_q;
		cfg_c.ys    = (hex_y_step_q == '0) ? STEP_W'(1) : hex_y_step_q;
		cfg_c.nodd  = sat_dim(cols_odd_q);
		cfg_c.neven = sat_dim(cols_even_q);
		cfg_c.nrows = sat_dim(rows_q);
	end

	// grid size, refreshed from the registers in two steps
	logic [CNT_W-1:0]   half_up, half_dn;
	logic [2*CNT_W-1:0] prod_odd_q, prod_even_q;
	logic [2*CNT_W:0]   total_raw;
	logic [24:0]        total_q;

	assign half_up   = CNT_W'(({1'b0, cfg_c.nrows} + 14'd1) >> 1);
	assign half_dn   = cfg_c.nrows >> 1;
	assign total_raw = {1'b0, prod_odd_q} + {1'b0, prod_even_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_odd_q  <= '0;
			prod_even_q <= '0;
			total_q     <= '0;
		end else begin
			prod_odd_q  <= half_up * cfg_c.nodd;
			prod_even_q <= half_dn * cfg_c.neven;
			total_q     <= (total_raw > 27'd16777216) ? 25'd16777216 : total_raw[24:0];
		end
	end

	// pipeline control: one enable for every stage
	logic           en;
	logic [LAT-1:0] vld_q;

	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// input stage and position products
	logic [11:0]      col_s1, row_s1;
	logic [NUM_W-1:0] xpos_s2, ypos_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			col_s1  <= out_col;
			row_s1  <= out_row;
			xpos_s2 <= NUM_W'(col_s1) * NUM_W'(sqr_x_res_q);
			ypos_s2 <= NUM_W'(row_s1) * NUM_W'(sqr_y_res_q);
		end
	end

	// positions ride along to the output
	logic [NUM_W-1:0] xpos_dly [0:LAT-2];
	logic [NUM_W-1:0] ypos_dly [0:LAT-2];
	assign xpos_dly[0] = xpos_s2;
	assign ypos_dly[0] = ypos_s2;
	for (genvar g = 1; g < LAT - 1; g++) begin : g_pos
		always_ff @(posedge clk) begin
			if (en) begin
				xpos_dly[g] <= xpos_dly[g-1];
				ypos_dly[g] <= ypos_dly[g-1];
			end
		end
	end
	assign x_pos = xpos_dly[LAT-2];
	assign y_pos = ypos_dly[LAT-2];

	logic [NUM_W-1:0]  ucol, row1;
	logic [STEP_W-1:0] rx, ry;

	hsg_div u_div_x (
		.clk (clk),
		.en  (en),
		.num (xpos_s2),
		.den (cfg_c.xs),
		.quo (ucol),
		.rem (rx)
	);

	hsg_div u_div_y (
		.clk (clk),
		.en  (en),
		.num (ypos_s2),
		.den (cfg_c.ys),
		.quo (row1),
		.rem (ry)
	);

	hsg_pick u_pick (
		.clk   (clk),
		.en    (en),
		.cfg   (cfg_c),
		.total (total_q),
		.ucol  (ucol),
		.rx    (rx),
		.row1  (row1),
		.ry    (ry),
		.index (source_index),
		.oor   (out_of_range)
	);

	`HSG_ASSERT_NOW(a_empty_flag, out_valid && total_q == '0, out_of_range && source_index == '0, "empty grid result not flagged")
	`HSG_ASSERT_NOW(a_in_grid, out_valid && !out_of_range, {1'b0, source_index} < total_q, "unflagged index past grid end")
	`HSG_ASSERT_NOW(a_clamp_last, out_valid && out_of_range && total_q != '0, {1'b0, source_index} == total_q - 25'd1, "clamped index is not the last sample")
	`HSG_ASSERT_NEXT(a_hold_valids, !en, $stable(vld_q), "pipeline moved during stall")

endmodule
